// ----- src/cci_pkg.sv -----
// Shared constants and types of the circle-circle intersection core.
// No dependencies.
`default_nettype none

package cci_pkg;

    localparam int COORD_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_TANGENT = 2'd1,
        KIND_TWO     = 2'd2,
        KIND_DEGEN   = 2'd3
    } kind_t;

endpackage

`default_nettype wire

// ----- src/cci_if.sv -----
// Valid/ready channels of the intersection core: circle pair in, crossing points out.
// Depends on cci_pkg.
`default_nettype none

interface cci_in_if #(
    parameter int COORD_WIDTH = cci_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_center_x;
    logic signed [COORD_WIDTH-1:0] first_center_y;
    logic        [COORD_WIDTH-2:0] first_radius;
    logic signed [COORD_WIDTH-1:0] second_center_x;
    logic signed [COORD_WIDTH-1:0] second_center_y;
    logic        [COORD_WIDTH-2:0] second_radius;

    modport source (
        output valid, first_center_x, first_center_y, first_radius,
        output second_center_x, second_center_y, second_radius,
        input  ready
    );
    modport sink (
        input  valid, first_center_x, first_center_y, first_radius,
        input  second_center_x, second_center_y, second_radius,
        output ready
    );
endinterface

interface cci_out_if #(
    parameter int COORD_WIDTH = cci_pkg::COORD_WIDTH_DEF
);
    import cci_pkg::*;

    logic                          valid;
    logic                          ready;
    kind_t                         intersection_kind;
    logic signed [COORD_WIDTH-1:0] point_a_x;
    logic signed [COORD_WIDTH-1:0] point_a_y;
    logic signed [COORD_WIDTH-1:0] point_b_x;
    logic signed [COORD_WIDTH-1:0] point_b_y;

    modport source (
        output valid, intersection_kind, point_a_x, point_a_y, point_b_x, point_b_y,
        input  ready
    );
    modport sink (
        input  valid, intersection_kind, point_a_x, point_a_y, point_b_x, point_b_y,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/cci_mul.sv -----
// Two-stage unsigned multiplier: four registered partial products, then their sum.
// No dependencies.
`default_nettype none

module cci_mul #(
    parameter int AW = 64,
    parameter int BW = 33
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [AW-1:0]      a,
    input  wire logic [BW-1:0]      b,
    output logic      [AW+BW-1:0]   p
);
    localparam int AL = AW / 2;
    localparam int AU = AW - AL;
    localparam int BL = BW / 2;
    localparam int BU = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] ll_reg, ll_next;
    logic [AL+BU-1:0] lh_reg, lh_next;
    logic [AU+BL-1:0] hl_reg, hl_next;
    logic [AU+BU-1:0] hh_reg, hh_next;
    logic [PW-1:0]    p_reg, p_next;

    always_comb
    begin
        ll_next = a[AL-1:0] * b[BL-1:0];
        lh_next = a[AL-1:0] * b[BW-1:BL];
        hl_next = a[AW-1:AL] * b[BL-1:0];
        hh_next = a[AW-1:AL] * b[BW-1:BL];
        p_next  = PW'(ll_reg) + (PW'(lh_reg) << BL) + (PW'(hl_reg) << AL)
                + (PW'(hh_reg) << (AL + BL));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= ll_next;
            lh_reg <= lh_next;
            hl_reg <= hl_next;
            hh_reg <= hh_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ----- src/cci_sqrt.sv -----
// Pipelined integer square root, one root bit per stage (floor of sqrt).
// No dependencies.
`default_nettype none

module cci_sqrt #(
    parameter int RW = 64
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [2*RW-1:0]   n,
    output logic      [RW-1:0]     root
);
    logic [2*RW-1:0] rem_reg  [RW-1];
    logic [RW-1:0]   root_reg [RW];

    for (genvar s = 0; s < RW; s++)
    begin : g_stage
        localparam int I = RW - 1 - s;
        logic [2*RW-1:0] rem_in;
        logic [RW-1:0]   root_in;
        logic [2*RW-1:0] trial;
        logic            fits;
        logic [RW-1:0]   root_next;

        if (s == 0)
        begin : g_first
            assign rem_in  = n;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        always_comb
        begin
            trial     = ((2*RW)'(root_in) << (I + 1)) | ((2*RW)'(1) << (2 * I));
            fits      = rem_in >= trial;
            root_next = fits ? root_in | (RW'(1) << I) : root_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[s] <= root_next;
            end
        end

        if (s < RW - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= fits ? rem_in - trial : rem_in;
                end
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

`default_nettype wire

// ----- src/cci_div.sv -----
// Pipelined signed division by a positive divisor, rounded to nearest, ties away from zero.
// One quotient bit per stage after a magnitude stage, then a rounding stage. No dependencies.
`default_nettype none

module cci_div #(
    parameter int SW = 99,
    parameter int DW = 65,
    parameter int QB = 34
) (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire logic [SW-1:0]   num,
    input  wire logic [DW-1:0]   den,
    output logic      [QB:0]     quo
);
    localparam int NW = SW - 1;

    logic [NW-1:0] mag0_reg, mag0_next;
    logic          neg0_reg;
    logic [DW-1:0] den0_reg;

    logic [NW-1:0] rem_reg [QB];
    logic [QB-1:0] q_reg   [QB];
    logic          neg_reg [QB];
    logic [DW-1:0] den_reg [QB];

    logic [QB-1:0] qr_next;
    logic [QB:0]   quo_reg, quo_next;

    assign mag0_next = num[SW-1] ? NW'(~num + 1'b1) : num[NW-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag0_reg <= mag0_next;
            neg0_reg <= num[SW-1];
            den0_reg <= den;
        end
    end

    for (genvar s = 0; s < QB; s++)
    begin : g_step
        localparam int I = QB - 1 - s;
        logic [NW-1:0] rem_in;
        logic [QB-1:0] q_in;
        logic          neg_in;
        logic [DW-1:0] den_in;
        logic [NW-1:0] dsh;
        logic [NW-1:0] rem_next;
        logic [QB-1:0] q_next;

        if (s == 0)
        begin : g_first
            assign rem_in = mag0_reg;
            assign q_in   = '0;
            assign neg_in = neg0_reg;
            assign den_in = den0_reg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign neg_in = neg_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        always_comb
        begin
            dsh      = NW'(den_in) << I;
            rem_next = (rem_in >= dsh) ? rem_in - dsh : rem_in;
            q_next   = (rem_in >= dsh) ? q_in | (QB'(1) << I) : q_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                q_reg[s]   <= q_next;
                neg_reg[s] <= neg_in;
                den_reg[s] <= den_in;
            end
        end
    end

    always_comb
    begin
        qr_next  = ({rem_reg[QB-1][DW-1:0], 1'b0} >= {1'b0, den_reg[QB-1]})
                 ? q_reg[QB-1] + 1'b1 : q_reg[QB-1];
        quo_next = neg_reg[QB-1] ? ~{1'b0, qr_next} + 1'b1 : {1'b0, qr_next};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

// ----- src/cci_dly.sv -----
// Enabled shift line that carries side data alongside the arithmetic stages.
// No dependencies.
`default_nettype none

module cci_dly #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [WIDTH-1:0]  d,
    output logic      [WIDTH-1:0]  q
);
    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

`default_nettype wire

// ----- src/circle_circle_intersection_core.sv -----
// Top level of the circle-circle intersection core: front stages, pipelined root and dividers.
// Depends on cci_pkg, cci_if, cci_mul, cci_sqrt, cci_div, cci_dly.
//
//   channel   dir  modport            beat
//   circles   in   cci_in_if.sink     two circles: centers and radii, Q16.16
//   points    out  cci_out_if.source  kind and up to two crossing points, saturated
//
// One beat enters per cycle while ready is high; a result's delay from its input beat is
// set by the 2*COORD_WIDTH-stage square root and the COORD_WIDTH+4-stage dividers.
// Reset clears valid bits and output flags only.
// An output register plus a skid register part the sides; ready drops only when both
// hold a beat, and then the whole pipeline holds.
`default_nettype none

module circle_circle_intersection_core #(
    parameter int COORD_WIDTH = cci_pkg::COORD_WIDTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cci_in_if.sink      circles,
    cci_out_if.source   points
);
    import cci_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int MW  = 2 * W;
    localparam int RW  = 2 * W;
    localparam int MDW = 2 * W + 1;
    localparam int PW  = 3 * W + 1;
    localparam int SW  = 3 * W + 3;
    localparam int QB  = W + 2;
    localparam int LAT = RW + QB + 10;
    localparam int LPW = MW + 2 * (W + 1);
    localparam int LSW = MDW + 3;
    localparam int LOW = 2 * W + 2;
    localparam int RSW = 2 + 4 * W;

    logic adv;
    logic v_reg [LAT];

    // stage A
    logic signed [W:0] dx_full, dy_full;
    logic [W:0]   adx_a_next, ady_a_next, adx_a_reg, ady_a_reg;
    logic         dxn_a_reg, dyn_a_reg;
    logic [W-1:0] rs_a_next, rs_a_reg;
    logic [W-2:0] rd_a_next, rd_a_reg, r1_a_reg, r2_a_reg;
    logic [W-1:0] x1_a_reg, y1_a_reg;

    // stage B
    logic [2*W+1:0] dx2_b_reg, dy2_b_reg;
    logic [2*W-3:0] r1sq_b_reg, r2sq_b_reg, dr2_b_reg;
    logic [2*W-1:0] sr2_b_reg;
    logic [W:0]     adx_b_reg, ady_b_reg;
    logic           dxn_b_reg, dyn_b_reg;
    logic [W-1:0]   x1_b_reg, y1_b_reg;

    // stage C
    logic [2*W+1:0] d2, sr2x, dr2x, f1_full, f2_full;
    logic [2*W+2:0] num_w, num_neg;
    kind_t          kind_c_next, kind_c_reg;
    logic [MW-1:0]  f1_c_reg, f2_c_reg, nmag_c_next, nmag_c_reg;
    logic           numn_c_reg;
    logic [MDW-1:0] m_c_reg;
    logic [W:0]     adx_c_reg, ady_c_reg;
    logic           dxn_c_reg, dyn_c_reg;
    logic [W-1:0]   x1_c_reg, y1_c_reg;

    // root and products
    logic [4*W-1:0] h_prod;
    logic [RW-1:0]  k_root;
    logic [LPW-1:0] lp_out;
    logic [LSW-1:0] ls_out;
    logic [LOW-1:0] lo_out;
    logic [MW-1:0]  nmag_d;
    logic [W:0]     adx_d, ady_d;
    logic [PW-1:0]  pn, pk, qn, qk;
    logic           numn_s, dxn_s, dyn_s;
    logic [MDW-1:0] m_s;

    // stage E
    logic [SW-1:0]  spn, spk, sqn, sqk;
    logic [SW-1:0]  ax_e_next, ay_e_next, bx_e_next, by_e_next;
    logic [SW-1:0]  ax_e_reg, ay_e_reg, bx_e_reg, by_e_reg;
    logic [MDW-1:0] m_e_reg;
    logic [QB:0]    qax, qay, qbx, qby;

    // result and output side
    kind_t          kind_o;
    logic [W-1:0]   x1_o, y1_o;
    logic [W-1:0]   rax, ray, rbx, rby;
    logic           pts_a, pts_b;
    logic [RSW-1:0] res_vec, out_data_reg, skid_data_reg;
    logic           out_valid_reg, skid_valid_reg;
    logic           v_last;

    function automatic logic [W-1:0] sat_add(input logic [W-1:0] base, input logic [QB:0] q);
        logic [W+3:0] s;
        logic [4:0]   top;
        s   = {{4{base[W-1]}}, base} + {q[QB], q};
        top = s[W+3:W-1];
        if ((&top) || !(|top))
        begin
            return s[W-1:0];
        end
        return s[W+3] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    assign adv           = !skid_valid_reg;
    assign circles.ready = adv;
    assign v_last        = v_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= circles.valid;
            for (int k = 1; k < LAT; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // stage A: differences and radius sum/difference
    always_comb
    begin
        dx_full = $signed({circles.second_center_x[W-1], circles.second_center_x})
                - $signed({circles.first_center_x[W-1], circles.first_center_x});
        dy_full = $signed({circles.second_center_y[W-1], circles.second_center_y})
                - $signed({circles.first_center_y[W-1], circles.first_center_y});
        adx_a_next = dx_full[W] ? ~dx_full + 1'b1 : dx_full;
        ady_a_next = dy_full[W] ? ~dy_full + 1'b1 : dy_full;
        rs_a_next  = {1'b0, circles.first_radius} + {1'b0, circles.second_radius};
        rd_a_next  = (circles.first_radius > circles.second_radius)
                   ? circles.first_radius - circles.second_radius
                   : circles.second_radius - circles.first_radius;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            adx_a_reg <= adx_a_next;
            ady_a_reg <= ady_a_next;
            dxn_a_reg <= dx_full[W];
            dyn_a_reg <= dy_full[W];
            rs_a_reg  <= rs_a_next;
            rd_a_reg  <= rd_a_next;
            r1_a_reg  <= circles.first_radius;
            r2_a_reg  <= circles.second_radius;
            x1_a_reg  <= circles.first_center_x;
            y1_a_reg  <= circles.first_center_y;
        end
    end

    // stage B: squares
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx2_b_reg  <= adx_a_reg * adx_a_reg;
            dy2_b_reg  <= ady_a_reg * ady_a_reg;
            r1sq_b_reg <= r1_a_reg * r1_a_reg;
            r2sq_b_reg <= r2_a_reg * r2_a_reg;
            sr2_b_reg  <= rs_a_reg * rs_a_reg;
            dr2_b_reg  <= rd_a_reg * rd_a_reg;
            adx_b_reg  <= adx_a_reg;
            ady_b_reg  <= ady_a_reg;
            dxn_b_reg  <= dxn_a_reg;
            dyn_b_reg  <= dyn_a_reg;
            x1_b_reg   <= x1_a_reg;
            y1_b_reg   <= y1_a_reg;
        end
    end

    // stage C: classify, Heron factors, base-point numerator
    always_comb
    begin
        d2      = dx2_b_reg + dy2_b_reg;
        sr2x    = (2*W+2)'(sr2_b_reg);
        dr2x    = (2*W+2)'(dr2_b_reg);
        f1_full = d2 - dr2x;
        f2_full = sr2x - d2;
        num_w   = (2*W+3)'(r1sq_b_reg) - (2*W+3)'(r2sq_b_reg) + (2*W+3)'(d2);
        num_neg = ~num_w + 1'b1;
        nmag_c_next = num_w[2*W+2] ? num_neg[MW-1:0] : num_w[MW-1:0];
        priority if (d2 > sr2x)
        begin
            kind_c_next = KIND_NONE;
        end
        else if (d2 == '0 || d2 < dr2x)
        begin
            kind_c_next = KIND_DEGEN;
        end
        else if (d2 == sr2x || d2 == dr2x)
        begin
            kind_c_next = KIND_TANGENT;
        end
        else
        begin
            kind_c_next = KIND_TWO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_c_reg <= kind_c_next;
            f1_c_reg   <= f1_full[MW-1:0];
            f2_c_reg   <= f2_full[MW-1:0];
            nmag_c_reg <= nmag_c_next;
            numn_c_reg <= num_w[2*W+2];
            m_c_reg    <= {d2[2*W-1:0], 1'b0};
            adx_c_reg  <= adx_b_reg;
            ady_c_reg  <= ady_b_reg;
            dxn_c_reg  <= dxn_b_reg;
            dyn_c_reg  <= dyn_b_reg;
            x1_c_reg   <= x1_b_reg;
            y1_c_reg   <= y1_b_reg;
        end
    end

    // h^2 scaled: ((r1+r2)^2 - d^2)(d^2 - (r1-r2)^2), then its root
    cci_mul #(.AW(MW), .BW(MW)) u_mul_h (
        .clk (clk), .en (adv), .a (f1_c_reg), .b (f2_c_reg), .p (h_prod)
    );

    cci_sqrt #(.RW(RW)) u_sqrt (
        .clk (clk), .en (adv), .n (h_prod), .root (k_root)
    );

    cci_dly #(.WIDTH(LPW), .DEPTH(RW + 2)) u_dly_p (
        .clk (clk), .en (adv), .d ({nmag_c_reg, adx_c_reg, ady_c_reg}), .q (lp_out)
    );

    cci_dly #(.WIDTH(LSW), .DEPTH(RW + 4)) u_dly_s (
        .clk (clk), .en (adv), .d ({numn_c_reg, dxn_c_reg, dyn_c_reg, m_c_reg}), .q (ls_out)
    );

    cci_dly #(.WIDTH(LOW), .DEPTH(RW + QB + 7)) u_dly_o (
        .clk (clk), .en (adv), .d ({kind_c_reg, x1_c_reg, y1_c_reg}), .q (lo_out)
    );

    assign {nmag_d, adx_d, ady_d}        = lp_out;
    assign {numn_s, dxn_s, dyn_s, m_s}   = ls_out;

    cci_mul #(.AW(MW), .BW(W + 1)) u_mul_pn (
        .clk (clk), .en (adv), .a (nmag_d), .b (adx_d), .p (pn)
    );
    cci_mul #(.AW(RW), .BW(W + 1)) u_mul_pk (
        .clk (clk), .en (adv), .a (k_root), .b (ady_d), .p (pk)
    );
    cci_mul #(.AW(MW), .BW(W + 1)) u_mul_qn (
        .clk (clk), .en (adv), .a (nmag_d), .b (ady_d), .p (qn)
    );
    cci_mul #(.AW(RW), .BW(W + 1)) u_mul_qk (
        .clk (clk), .en (adv), .a (k_root), .b (adx_d), .p (qk)
    );

    // stage E: signed numerators of the four coordinates
    always_comb
    begin
        spn = (dxn_s ^ numn_s) ? ~{2'b00, pn} + 1'b1 : {2'b00, pn};
        spk = dyn_s            ? ~{2'b00, pk} + 1'b1 : {2'b00, pk};
        sqn = (dyn_s ^ numn_s) ? ~{2'b00, qn} + 1'b1 : {2'b00, qn};
        sqk = dxn_s            ? ~{2'b00, qk} + 1'b1 : {2'b00, qk};
        ax_e_next = spn + spk;
        ay_e_next = sqn - sqk;
        bx_e_next = spn - spk;
        by_e_next = sqn + sqk;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_e_reg <= ax_e_next;
            ay_e_reg <= ay_e_next;
            bx_e_reg <= bx_e_next;
            by_e_reg <= by_e_next;
            m_e_reg  <= m_s;
        end
    end

    cci_div #(.SW(SW), .DW(MDW), .QB(QB)) u_div_ax (
        .clk (clk), .en (adv), .num (ax_e_reg), .den (m_e_reg), .quo (qax)
    );
    cci_div #(.SW(SW), .DW(MDW), .QB(QB)) u_div_ay (
        .clk (clk), .en (adv), .num (ay_e_reg), .den (m_e_reg), .quo (qay)
    );
    cci_div #(.SW(SW), .DW(MDW), .QB(QB)) u_div_bx (
        .clk (clk), .en (adv), .num (bx_e_reg), .den (m_e_reg), .quo (qbx)
    );
    cci_div #(.SW(SW), .DW(MDW), .QB(QB)) u_div_by (
        .clk (clk), .en (adv), .num (by_e_reg), .den (m_e_reg), .quo (qby)
    );

    // final: offset from first center, saturate, blank unused points
    always_comb
    begin
        kind_o = kind_t'(lo_out[LOW-1:LOW-2]);
        x1_o   = lo_out[2*W-1:W];
        y1_o   = lo_out[W-1:0];
        pts_a  = (kind_o == KIND_TANGENT) || (kind_o == KIND_TWO);
        pts_b  = (kind_o == KIND_TWO);
        rax    = pts_a ? sat_add(x1_o, qax) : '0;
        ray    = pts_a ? sat_add(y1_o, qay) : '0;
        rbx    = pts_b ? sat_add(x1_o, qbx) : '0;
        rby    = pts_b ? sat_add(y1_o, qby) : '0;
        res_vec = {kind_o, rax, ray, rbx, rby};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || points.ready)
        begin
            out_valid_reg  <= skid_valid_reg || v_last;
            skid_valid_reg <= 1'b0;
        end
        else if (v_last && adv)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || points.ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_vec;
        end
        else if (v_last && adv)
        begin
            skid_data_reg <= res_vec;
        end
    end

    assign points.valid             = out_valid_reg;
    assign points.intersection_kind = kind_t'(out_data_reg[RSW-1:RSW-2]);
    assign points.point_a_x         = out_data_reg[4*W-1:3*W];
    assign points.point_a_y         = out_data_reg[3*W-1:2*W];
    assign points.point_b_x         = out_data_reg[2*W-1:W];
    assign points.point_b_y         = out_data_reg[W-1:0];

endmodule

`default_nettype wire

// ----- src/cci_chk.sv -----
// Port-level checks of the intersection core, bound to the top level.
// Depends on cci_pkg and circle_circle_intersection_core.
`default_nettype none

module cci_chk #(
    parameter int COORD_WIDTH = cci_pkg::COORD_WIDTH_DEF
) (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [1:0]             kind,
    input wire logic [COORD_WIDTH-1:0] ax,
    input wire logic [COORD_WIDTH-1:0] ay,
    input wire logic [COORD_WIDTH-1:0] bx,
    input wire logic [COORD_WIDTH-1:0] by
);
    import cci_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(ax)
            && $stable(ay) && $stable(bx) && $stable(by))
        else $error("output beat changed while stalled");

    a_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_NONE || kind == KIND_DEGEN)
            |-> ax == '0 && ay == '0 && bx == '0 && by == '0)
        else $error("points set for a pair without crossings");

    a_tangent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_TANGENT |-> bx == '0 && by == '0)
        else $error("second point set for a tangent pair");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input held off with no output beat waiting");

endmodule

bind circle_circle_intersection_core cci_chk #(.COORD_WIDTH(COORD_WIDTH)) u_cci_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (circles.ready),
    .out_valid (points.valid),
    .out_ready (points.ready),
    .kind      (points.intersection_kind),
    .ax        (points.point_a_x),
    .ay        (points.point_a_y),
    .bx        (points.point_b_x),
    .by        (points.point_b_y)
);

`default_nettype wire
